// ===== sv/polynomial_inverse_newton_assert.svh =====
// Assertion macros for the polynomial inverse block.
`ifndef POLYNOMIAL_INVERSE_NEWTON_ASSERT_SVH
`define POLYNOMIAL_INVERSE_NEWTON_ASSERT_SVH
// Consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
// Consequent holds in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`endif

// ===== sv/pin_pkg.sv =====
// ----------------------------------------------------------------------------
// pin_pkg
// Shared types and codes of the polynomial inverse block.
// ----------------------------------------------------------------------------
`default_nettype none
package pin_pkg;
    localparam int WORD_W = 32;

    // shared unit operations
    localparam logic [1:0] OP_MUL = 2'd0;
    localparam logic [1:0] OP_DIV = 2'd1;

    typedef struct packed {
        logic              start;
        logic [1:0]        op;
        logic signed [31:0] a;
        logic signed [31:0] b;
    } alu_req_t;

    typedef struct packed {
        logic              done;
        logic signed [31:0] res;
    } alu_rsp_t;
endpackage
`default_nettype wire

// ===== sv/polynomial_inverse_newton.sv =====
// ----------------------------------------------------------------------------
// polynomial_inverse_newton
// Solves p(t) = target by Newton iteration in signed fixed point.
// ----------------------------------------------------------------------------
// channel  | dir | fields
// s_axis   | in  | tdata: target[31:0], start_guess[63:32]
// m_axis   | out | tdata: solution[31:0]
// apb      | in  | degree, coef_0..4, tolerance, iteration_limit at 4*i
//
// Per Newton step, the sequencer issues 2*degree multiplies for q(t) and
// 2*(degree-1) for q'(t), then at most one division, all on the single
// shared multiply/divide unit; up to iteration_limit steps.
// s_axis_tready is high only while the sequencer is idle; a finished result
// holds in the sequencer while the previous one still waits on m_axis.
// Reset clears the sequencer and loads the register reset values.
// ----------------------------------------------------------------------------
`default_nettype none
module polynomial_inverse_newton
    import pin_pkg::*;
#(
    parameter int MAX_DEGREE = 4,
    parameter int FRAC_BITS  = 16
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [63:0] s_axis_tdata,   // target[31:0], start_guess[63:32]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [31:0] m_axis_tdata    // solution[31:0]
);
    localparam logic [2:0] REG_DEGREE = 3'd0;
    localparam logic [2:0] REG_TOL    = 3'd6;
    localparam logic [2:0] REG_LIMIT  = 3'd7;
    localparam int DEG_W = 3;
    localparam logic [DEG_W-1:0] MAXD = DEG_W'(MAX_DEGREE);
    localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_PREP  = 4'd1;
    localparam logic [3:0] ST_ITER  = 4'd2;
    localparam logic [3:0] ST_POW   = 4'd3;
    localparam logic [3:0] ST_TERM  = 4'd4;
    localparam logic [3:0] ST_CHECK = 4'd5;
    localparam logic [3:0] ST_DIV   = 4'd6;
    localparam logic [3:0] ST_WAIT  = 4'd7;
    localparam logic [3:0] ST_OUT   = 4'd8;

    logic [2:0]        degree_reg;
    logic signed [31:0] coef_reg [0:4];
    logic [30:0]       tol_reg;
    logic [7:0]        limit_reg;

    logic [3:0]        state_reg, state_next;
    logic [3:0]        ret_reg, ret_next;
    logic              pass_reg, pass_next;    // 0: q(t), 1: q'(t)
    logic [DEG_W-1:0]  k_reg, k_next;
    logic [7:0]        it_reg, it_next;
    logic signed [31:0] t_reg, t_next;
    logic signed [31:0] q0_reg, q0_next;
    logic signed [31:0] acc_reg, acc_next;
    logic signed [31:0] tp_reg, tp_next;
    logic signed [31:0] r_reg, r_next;
    logic signed [31:0] resid_reg, resid_next;
    logic [DEG_W-1:0]  deg_reg, deg_next;
    logic              outv_reg, outv_next;
    alu_req_t          req;
    alu_rsp_t          rsp;

    logic signed [32:0] dif;
    logic signed [35:0] kc;
    logic signed [31:0] cterm;
    logic [DEG_W-1:0]   top;
    logic signed [31:0] kcs;

    pin_alu #(.FRAC_BITS(FRAC_BITS)) u_alu
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
        if (v > 33'sd2147483647)
            return 32'sh7fffffff;
        else if (v < -33'sd2147483648)
            return 32'sh80000000;
        else
            return v[31:0];
    endfunction

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            degree_reg <= '0;
            for (int i = 0; i < 5; i++)
                coef_reg[i] <= '0;
            tol_reg   <= 31'd66;
            limit_reg <= 8'd16;
        end
        else if (psel && penable && pwrite)
        begin
            case (paddr[4:2])
                REG_DEGREE: degree_reg <= pwdata[2:0];
                REG_TOL:    tol_reg    <= pwdata[30:0];
                REG_LIMIT:  limit_reg  <= pwdata[7:0];
                default:    coef_reg[3'(paddr[4:2] - 3'd1)] <= pwdata;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:2])
            REG_DEGREE: prdata = {29'd0, degree_reg};
            REG_TOL:    prdata = {1'b0, tol_reg};
            REG_LIMIT:  prdata = {24'd0, limit_reg};
            default:    prdata = coef_reg[3'(paddr[4:2] - 3'd1)];
        endcase
    end

    // coefficient of the current term: q_k, or k+1 times q_(k+1) for q'
    always_comb
    begin
        kc  = 36'(coef_reg[3'(k_reg + (pass_reg ? 3'd1 : 3'd0))])
              * $signed({1'b0, 3'(k_reg + 3'd1)});
        if (kc > 36'sd2147483647)
            kcs = 32'sh7fffffff;
        else if (kc < -36'sd2147483648)
            kcs = 32'sh80000000;
        else
            kcs = kc[31:0];
        cterm = pass_reg ? kcs : coef_reg[k_reg];
        top   = pass_reg ? ((deg_reg == 0) ? 3'd0 : 3'(deg_reg - 3'd1)) : deg_reg;
        dif   = 33'(t_reg) - 33'(rsp.res);
    end

    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        pass_next  = pass_reg;
        k_next     = k_reg;
        it_next    = it_reg;
        t_next     = t_reg;
        q0_next    = q0_reg;
        acc_next   = acc_reg;
        tp_next    = tp_reg;
        r_next     = r_reg;
        resid_next = resid_reg;
        deg_next   = deg_reg;
        outv_next  = outv_reg;
        req.start  = 1'b0;
        req.op     = OP_MUL;
        req.a      = tp_reg;
        req.b      = t_reg;
        if (outv_reg && m_axis_tready)
            outv_next = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    t_next   = s_axis_tdata[63:32];
                    q0_next  = sat33(33'(coef_reg[0]) - 33'($signed(s_axis_tdata[31:0])));
                    deg_next = (degree_reg > MAXD) ? MAXD : degree_reg;
                    it_next  = '0;
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                // start one evaluation pass, or go to output once the iteration limit is reached
                if (it_reg == limit_reg && !pass_reg)
                    state_next = ST_OUT;
                else
                begin
                    acc_next = pass_reg ? kcs : q0_reg;
                    k_next   = 3'd1;
                    tp_next  = ONE;
                    state_next = ST_ITER;
                end
                if (pass_reg)
                begin
                    k_next = 3'd0;
                    acc_next = cterm;
                    tp_next = ONE;
                    k_next = 3'd1;
                    // acc for q' starts at 1*q_1 which is cterm with k=0
                end
            end
            ST_ITER:
            begin
                if (k_reg > top)
                    state_next = ST_CHECK;
                else
                begin
                    req.start = 1'b1;
                    req.op = OP_MUL;
                    req.a = tp_reg;
                    req.b = t_reg;
                    ret_next = ST_POW;
                    state_next = ST_WAIT;
                end
            end
            ST_POW:
            begin
                tp_next = r_reg;
                req.start = 1'b1;
                req.op = OP_MUL;
                req.a = cterm;
                req.b = r_reg;
                ret_next = ST_TERM;
                state_next = ST_WAIT;
            end
            ST_TERM:
            begin
                acc_next = sat33(33'(acc_reg) + 33'(r_reg));
                k_next = 3'(k_reg + 3'd1);
                state_next = ST_ITER;
            end
            ST_WAIT:
            begin
                if (rsp.done)
                begin
                    r_next = rsp.res;
                    if (ret_reg == ST_DIV)
                    begin
                        t_next = sat33(dif);
                        it_next = it_reg + 8'd1;
                        pass_next = 1'b0;
                        state_next = ST_PREP;
                    end
                    else
                        state_next = ret_reg;
                end
            end
            ST_CHECK:
            begin
                if (!pass_reg)
                begin
                    if ($signed({acc_reg[31], acc_reg}) > -$signed({2'b0, tol_reg})
                        && $signed({acc_reg[31], acc_reg}) < $signed({2'b0, tol_reg}))
                        state_next = ST_OUT;
                    else
                    begin
                        q0_next = q0_reg;
                        r_next = acc_reg;
                        resid_next = acc_reg;
                        tp_next = acc_reg;
                        pass_next = 1'b1;
                        state_next = ST_PREP;
                    end
                end
                else if (acc_reg == 32'sd0)
                    state_next = ST_OUT;
                else
                begin
                    req.start = 1'b1;
                    req.op = OP_DIV;
                    req.a = resid_reg;
                    req.b = acc_reg;
                    ret_next = ST_DIV;
                    state_next = ST_WAIT;
                end
            end
            ST_DIV:
                state_next = ST_PREP;
            ST_OUT:
            begin
                // hold the finished result until the previous one has left
                if (!outv_reg || m_axis_tready)
                begin
                    outv_next = 1'b1;
                    pass_next = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
        // cterm in ST_PREP uses k_reg which is stale; q' starts at 1*q_1,
        // or at zero when the polynomial is a constant
        if (state_reg == ST_PREP && pass_reg)
            acc_next = (deg_reg == 3'd0) ? 32'sd0 : coef_reg[1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ret_reg   <= ST_IDLE;
            pass_reg  <= 1'b0;
            outv_reg  <= 1'b0;
            it_reg    <= '0;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            pass_reg  <= pass_next;
            outv_reg  <= outv_next;
            it_reg    <= it_next;
            k_reg     <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        t_reg     <= t_next;
        q0_reg    <= q0_next;
        acc_reg   <= acc_next;
        tp_reg    <= tp_next;
        r_reg     <= r_next;
        resid_reg <= resid_next;
        deg_reg   <= deg_next;
        if (state_reg == ST_OUT && (!outv_reg || m_axis_tready))
            m_axis_tdata <= t_reg;
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = outv_reg;
endmodule
`default_nettype wire

// ===== sv/pin_alu.sv =====
// ----------------------------------------------------------------------------
// pin_alu
// Shared arithmetic unit: saturated fixed-point multiply (split into four
// 16x16 partial products) or serial restoring division of a*2^F by b.
// ----------------------------------------------------------------------------
`default_nettype none
module pin_alu
    import pin_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire alu_req_t req,
    output alu_rsp_t      rsp
);
    localparam int NUM_W = 32 + FRAC_BITS;
    localparam int CNT_W = $clog2(NUM_W + 1);
    localparam logic signed [63:0] MAX64 = 64'sd2147483647;
    localparam logic signed [63:0] MIN64 = -64'sd2147483648;

    logic              busy_reg, busy_next;
    logic [1:0]        op_reg, op_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              neg_reg, neg_next;
    logic [31:0]       ua_reg, ua_next;
    logic [31:0]       ub_reg, ub_next;
    logic [63:0]       acc_reg, acc_next;
    logic [NUM_W-1:0]  num_reg, num_next;
    logic [32:0]       rem_reg, rem_next;
    logic              done_reg, done_next;
    logic signed [31:0] res_reg, res_next;

    logic [15:0] pa, pb;
    logic [31:0] pp;
    logic [63:0] pps;
    logic [32:0] trial;
    logic signed [64:0] sprod;
    logic signed [64:0] shq;
    logic signed [64:0] squo;

    always_comb
    begin
        pa = cnt_reg[0] ? ua_reg[31:16] : ua_reg[15:0];
        pb = cnt_reg[1] ? ub_reg[31:16] : ub_reg[15:0];
        pp = pa * pb;
        pps = {32'd0, pp} << (16 * (32'(cnt_reg[0]) + 32'(cnt_reg[1])));
        trial = {rem_reg[31:0], num_reg[NUM_W-1]} - {1'b0, ub_reg};
        sprod = neg_reg ? -$signed({1'b0, acc_reg}) : $signed({1'b0, acc_reg});
        shq = sprod >>> FRAC_BITS;
        squo = neg_reg ? -$signed({{(65-NUM_W){1'b0}}, num_reg})
                       : $signed({{(65-NUM_W){1'b0}}, num_reg});
    end

    always_comb
    begin
        busy_next = busy_reg;
        op_next   = op_reg;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        ua_next   = ua_reg;
        ub_next   = ub_reg;
        acc_next  = acc_reg;
        num_next  = num_reg;
        rem_next  = rem_reg;
        done_next = 1'b0;
        res_next  = res_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            op_next   = req.op;
            cnt_next  = '0;
            neg_next  = req.a[31] ^ req.b[31];
            ua_next   = req.a[31] ? 32'(-req.a) : req.a;
            ub_next   = req.b[31] ? 32'(-req.b) : req.b;
            acc_next  = '0;
            rem_next  = '0;
            num_next  = {(req.a[31] ? 32'(-req.a) : 32'(req.a)),
                         {FRAC_BITS{1'b0}}};
        end
        else if (busy_reg)
        begin
            case (op_reg)
                OP_MUL:
                begin
                    if (cnt_reg == CNT_W'(4))
                    begin
                        busy_next = 1'b0;
                        done_next = 1'b1;
                        if (shq > 65'(MAX64))
                            res_next = 32'sh7fffffff;
                        else if (shq < 65'(MIN64))
                            res_next = 32'sh80000000;
                        else
                            res_next = shq[31:0];
                    end
                    else
                    begin
                        acc_next = acc_reg + pps;
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
                OP_DIV:
                begin
                    if (cnt_reg == CNT_W'(NUM_W))
                    begin
                        busy_next = 1'b0;
                        done_next = 1'b1;
                        if (squo > 65'(MAX64))
                            res_next = 32'sh7fffffff;
                        else if (squo < 65'(MIN64))
                            res_next = 32'sh80000000;
                        else
                            res_next = squo[31:0];
                    end
                    else
                    begin
                        // shift one numerator bit in, subtract if it fits
                        if (!trial[32])
                            rem_next = trial;
                        else
                            rem_next = {rem_reg[31:0], num_reg[NUM_W-1]};
                        num_next = {num_reg[NUM_W-2:0], ~trial[32]};
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
                default:
                begin
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            op_reg   <= OP_MUL;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            op_reg   <= op_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        ua_reg  <= ua_next;
        ub_reg  <= ub_next;
        acc_reg <= acc_next;
        num_reg <= num_next;
        rem_reg <= rem_next;
        res_reg <= res_next;
    end

    assign rsp.done = done_reg;
    assign rsp.res  = res_reg;
endmodule
`default_nettype wire

// ===== sv/pin_checker.sv =====
// ----------------------------------------------------------------------------
// pin_checker
// Port-level checks of the polynomial inverse block.
// ----------------------------------------------------------------------------
`default_nettype none
`include "polynomial_inverse_newton_assert.svh"
module pin_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        pready,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [31:0] m_axis_tdata
);
    `ASSERT_NEXT(a_busy_after_in, clk, rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    `ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
    `ASSERT_SAME(a_pready, clk, rst_n, 1'b1, pready)
endmodule

bind polynomial_inverse_newton pin_checker u_pin_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire
